@@ hdl/tmsp_pkg.sv @@
// Shared constants, types and state codes of the temporal miss-stream prefetcher.
// No dependencies; every other file except tmsp_ram imports this package.
`default_nettype none

package tmsp_pkg;

   localparam int HIST_DEPTH      = 1024;
   localparam int INDEX_ENTRIES   = 128;
   localparam int PAIRS_PER_ENTRY = 8;
   localparam int BURST           = 8;
   localparam int REPLAY_DEPTH    = 128;
   localparam int LINE_LOG2       = 6;

   localparam int ADDR_W  = 48;
   localparam int PC_W    = 48;
   localparam int CORE_W  = 3;
   localparam int LINE_W  = 42;
   localparam int PTR_W   = 32;
   localparam int TIMER_W = 2;
   localparam int UCNT_W  = 3;

   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
   localparam int ENT_AW     = $clog2(INDEX_ENTRIES);
   localparam int PAIR_JW    = (PAIRS_PER_ENTRY > 1) ? $clog2(PAIRS_PER_ENTRY) : 1;
   localparam int PAIR_DEPTH = INDEX_ENTRIES * (2 ** PAIR_JW);
   localparam int PAIR_AW    = ENT_AW + PAIR_JW;
   localparam int RQ_AW      = $clog2(REPLAY_DEPTH);
   localparam int BURST_CW   = (BURST > 1) ? $clog2(BURST) : 1;

   typedef enum logic {
      KIND_MISS,
      KIND_HIT
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   line_addr;
      logic [PC_W-1:0]     load_pc;
      logic [CORE_W-1:0]   core_id;
   } item_type;

   typedef struct packed {
      logic [PTR_W-1:0]           recent_ptr;
      logic [UCNT_W-1:0]          upd_count;
      logic [PAIRS_PER_ENTRY-1:0] pair_valid;
   } meta_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  succ_key;
      logic [PTR_W-1:0]   hist_ptr;
      logic [TIMER_W-1:0] timer;
   } pair_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FIND_HEAD,
      ST_META_HEAD,
      ST_PAIR_HEAD,
      ST_FIND_ADDR,
      ST_META_ADDR,
      ST_REFILL,
      ST_DRAIN,
      ST_RECORD,
      ST_EV_SCAN,
      ST_EV_PAIR,
      ST_EV_FIN,
      ST_PREV,
      ST_FIND_PREV,
      ST_UPD_META,
      ST_UPD_PAIR,
      ST_UPD_WR
   } state_type;

endpackage

`default_nettype wire

@@ hdl/tmsp_if.sv @@
// Valid/ready channel interfaces for the event input and the prefetch request output.
// Depends on tmsp_pkg for field widths.
`default_nettype none

interface tmsp_req_if
   import tmsp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] line_addr;
   logic              is_hit;
   logic [PC_W-1:0]   load_pc;
   logic [CORE_W-1:0] core_id;

   modport source (output valid, line_addr, is_hit, load_pc, core_id, input ready);
   modport sink (input valid, line_addr, is_hit, load_pc, core_id, output ready);
endinterface

interface tmsp_rsp_if
   import tmsp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [LINE_W-1:0] prefetch_line;
   logic [PC_W-1:0]   req_pc;
   logic [CORE_W-1:0] req_core;
   logic              last;

   modport source (output valid, prefetch_line, req_pc, req_core, last, input ready);
   modport sink (input valid, prefetch_line, req_pc, req_core, last, output ready);
endinterface

`default_nettype wire

@@ hdl/tmsp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module tmsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

@@ hdl/tmsp_front.sv @@
// Front end: accepts events, classifies them as hit or miss and queues them.
// Depends on tmsp_pkg and tmsp_if.
`default_nettype none

module tmsp_front
   import tmsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   tmsp_req_if.sink req_chan,
   output logic     item_valid,
   input  logic     item_ready,
   output item_type item
);
   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;
   item_type    new_item;

   always_comb begin
      new_item.kind      = req_chan.is_hit ? KIND_HIT : KIND_MISS;
      new_item.line_addr = req_chan.line_addr;
      new_item.load_pc   = req_chan.load_pc;
      new_item.core_id   = req_chan.core_id;
      req_chan.ready     = (count_ff != 2'd2);
      push               = req_chan.valid && req_chan.ready;
      item_valid         = (count_ff != 2'd0);
      item               = slot_ff[rd_ptr_ff];
      pop                = item_valid && item_ready;
      wr_ptr_in          = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in          = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in           = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule

`default_nettype wire

@@ hdl/tmsp_back.sv @@
// Back end: sequencer that looks up the index, refills and drains the replay queue,
// and records each event in the history. Depends on tmsp_pkg, tmsp_if, tmsp_ram.
`default_nettype none

module tmsp_back
   import tmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   output logic        item_ready,
   input  item_type    item,
   tmsp_rsp_if.source  rsp_chan
);
   state_type state_ff, state_in;
   logic      phase_ff, phase_in;
   item_type  item_ff, item_in;

   logic [ADDR_W-1:0]  stream_head_ff, stream_head_in;
   logic               stream_valid_ff, stream_valid_in;
   logic [ADDR_W-1:0]  prev_ff, prev_in;
   logic               prev_valid_ff, prev_valid_in;
   logic [PTR_W-1:0]   total_ff, total_in;
   logic [HIST_CW-1:0] fill_ff, fill_in;
   logic [HIST_AW-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0]  old_ff, old_in;
   logic [ADDR_W-1:0]  find_key_ff, find_key_in;

   logic [INDEX_ENTRIES-1:0] valid_ff, valid_in;
   logic [ENT_AW-1:0]  ent_cnt_ff, ent_cnt_in;
   logic [ENT_AW-1:0]  ent_sel_ff, ent_sel_in;
   logic [PAIR_JW-1:0] pj_ff, pj_in;
   logic [RQ_AW-1:0]   ri_ff, ri_in;
   logic [PTR_W-1:0]   start_ff, start_in;
   logic [RQ_AW-1:0]   rq_head_ff, rq_head_in;
   logic [RQ_AW-1:0]   rq_count_ff, rq_count_in;
   logic [BURST_CW-1:0] burst_ff, burst_in;
   meta_type           meta_ff, meta_in;

   logic               free_found_ff, free_found_in;
   logic [ENT_AW-1:0]  free_ent_ff, free_ent_in;
   logic [PAIR_JW-1:0] free_j_ff, free_j_in;
   logic               small_found_ff, small_found_in;
   logic [ENT_AW-1:0]  small_ent_ff, small_ent_in;
   logic [PAIR_JW-1:0] small_j_ff, small_j_in;
   logic [ADDR_W-1:0]  small_key_ff, small_key_in;
   logic               hit_found_ff, hit_found_in;
   logic [PAIR_JW-1:0] hit_j_ff, hit_j_in;
   pair_type           hit_pair_ff, hit_pair_in;

   logic               out_valid_ff, out_valid_in;
   logic [LINE_W-1:0]  out_line_ff, out_line_in;
   logic [PC_W-1:0]    out_pc_ff, out_pc_in;
   logic [CORE_W-1:0]  out_core_ff, out_core_in;
   logic               out_last_ff, out_last_in;

   // memory ports
   logic               hist_wr_en;
   logic [HIST_AW-1:0] hist_wr_addr, hist_rd_addr;
   logic [ADDR_W-1:0]  hist_wr_data, hist_rd_data;
   logic               key_wr_en;
   logic [ENT_AW-1:0]  key_wr_addr;
   logic [ADDR_W-1:0]  key_wr_data, key_rd_data;
   logic               meta_wr_en;
   logic [ENT_AW-1:0]  meta_wr_addr, meta_rd_addr;
   meta_type           meta_wr_data, meta_rd_data;
   logic               pair_wr_en;
   logic [PAIR_AW-1:0] pair_wr_addr, pair_rd_addr;
   pair_type           pair_wr_data, pair_rd_data;
   logic               rq_wr_en;
   logic [RQ_AW-1:0]   rq_wr_addr;
   logic [ADDR_W-1:0]  rq_wr_data, rq_rd_data;

   // refill window
   logic [PTR_W-1:0]   pos, age;
   logic               pos_ok;
   logic [HIST_CW-1:0] age_n;
   logic [HIST_CW:0]   slot_calc;
   logic [HIST_AW-1:0] refill_slot;

   logic               out_free;
   logic               ent_last, pj_last, ri_last, ent_match_v;
   logic [ENT_AW-1:0]  alloc_ent;
   logic [PAIR_JW-1:0] upd_j;
   logic [PTR_W-1:0]   upd_ptr;
   logic               burst_last;

   tmsp_ram #(.WIDTH(ADDR_W), .DEPTH(HIST_DEPTH)) u_hist (
      .clock, .wr_en(hist_wr_en), .wr_addr(hist_wr_addr), .wr_data(hist_wr_data),
      .rd_addr(hist_rd_addr), .rd_data(hist_rd_data));
   tmsp_ram #(.WIDTH(ADDR_W), .DEPTH(INDEX_ENTRIES)) u_key (
      .clock, .wr_en(key_wr_en), .wr_addr(key_wr_addr), .wr_data(key_wr_data),
      .rd_addr(ent_cnt_ff), .rd_data(key_rd_data));
   tmsp_ram #(.WIDTH($bits(meta_type)), .DEPTH(INDEX_ENTRIES)) u_meta (
      .clock, .wr_en(meta_wr_en), .wr_addr(meta_wr_addr), .wr_data(meta_wr_data),
      .rd_addr(meta_rd_addr), .rd_data(meta_rd_data));
   tmsp_ram #(.WIDTH($bits(pair_type)), .DEPTH(PAIR_DEPTH)) u_pair (
      .clock, .wr_en(pair_wr_en), .wr_addr(pair_wr_addr), .wr_data(pair_wr_data),
      .rd_addr(pair_rd_addr), .rd_data(pair_rd_data));
   tmsp_ram #(.WIDTH(ADDR_W), .DEPTH(REPLAY_DEPTH)) u_rq (
      .clock, .wr_en(rq_wr_en), .wr_addr(rq_wr_addr), .wr_data(rq_wr_data),
      .rd_addr(rq_head_ff), .rd_data(rq_rd_data));

   always_comb begin
      // replay window position for the current refill step
      pos         = start_ff + PTR_W'(ri_ff);
      age         = total_ff - pos;
      pos_ok      = (age != '0) && (age <= PTR_W'(fill_ff));
      age_n       = HIST_CW'(age);
      if ({1'b0, HIST_CW'(slot_ff)} >= {1'b0, age_n}) begin
         slot_calc = {1'b0, HIST_CW'(slot_ff)} - {1'b0, age_n};
      end else begin
         slot_calc = {1'b0, HIST_CW'(slot_ff)} + (HIST_CW + 1)'(HIST_DEPTH) - {1'b0, age_n};
      end
      refill_slot = HIST_AW'(slot_calc);

      ent_last    = (ent_cnt_ff == ENT_AW'(INDEX_ENTRIES - 1));
      pj_last     = (pj_ff == PAIR_JW'(PAIRS_PER_ENTRY - 1));
      ri_last     = (ri_ff == RQ_AW'(REPLAY_DEPTH - 1));
      burst_last  = (burst_ff == BURST_CW'(BURST - 1));
      ent_match_v = valid_ff[ent_cnt_ff];
      out_free    = !out_valid_ff || rsp_chan.ready;
      upd_ptr     = total_ff - PTR_W'(1);

      hist_rd_addr = (state_ff == ST_REFILL) ? refill_slot : slot_ff;
      meta_rd_addr = (state_ff == ST_EV_SCAN) ? ent_cnt_ff : ent_sel_ff;
      pair_rd_addr = (state_ff == ST_EV_PAIR) ? {ent_cnt_ff, pj_ff} : {ent_sel_ff, pj_ff};

      hist_wr_en   = 1'b0;
      hist_wr_addr = slot_ff;
      hist_wr_data = item_ff.line_addr;
      key_wr_en    = 1'b0;
      key_wr_addr  = ent_cnt_ff;
      key_wr_data  = prev_ff;
      meta_wr_en   = 1'b0;
      meta_wr_addr = ent_cnt_ff;
      meta_wr_data = meta_ff;
      pair_wr_en   = 1'b0;
      pair_wr_addr = {ent_sel_ff, pj_ff};
      pair_wr_data = hit_pair_ff;
      rq_wr_en     = 1'b0;
      rq_wr_addr   = rq_count_ff;
      rq_wr_data   = hist_rd_data;
      alloc_ent    = ent_cnt_ff;
      upd_j        = pj_ff;

      state_in        = state_ff;
      phase_in        = phase_ff;
      item_in         = item_ff;
      stream_head_in  = stream_head_ff;
      stream_valid_in = stream_valid_ff;
      prev_in         = prev_ff;
      prev_valid_in   = prev_valid_ff;
      total_in        = total_ff;
      fill_in         = fill_ff;
      slot_in         = slot_ff;
      old_in          = old_ff;
      find_key_in     = find_key_ff;
      valid_in        = valid_ff;
      ent_cnt_in      = ent_cnt_ff;
      ent_sel_in      = ent_sel_ff;
      pj_in           = pj_ff;
      ri_in           = ri_ff;
      start_in        = start_ff;
      rq_head_in      = rq_head_ff;
      rq_count_in     = rq_count_ff;
      burst_in        = burst_ff;
      meta_in         = meta_ff;
      free_found_in   = free_found_ff;
      free_ent_in     = free_ent_ff;
      free_j_in       = free_j_ff;
      small_found_in  = small_found_ff;
      small_ent_in    = small_ent_ff;
      small_j_in      = small_j_ff;
      small_key_in    = small_key_ff;
      hit_found_in    = hit_found_ff;
      hit_j_in        = hit_j_ff;
      hit_pair_in     = hit_pair_ff;
      out_valid_in    = out_valid_ff && !rsp_chan.ready;
      out_line_in     = out_line_ff;
      out_pc_in       = out_pc_ff;
      out_core_in     = out_core_ff;
      out_last_in     = out_last_ff;
      item_ready      = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            phase_in = 1'b0;
            if (item_valid) begin
               item_in  = item;
               burst_in = '0;
               ent_cnt_in = '0;
               if (item.kind == KIND_HIT) begin
                  stream_valid_in = 1'b0;
                  state_in        = ST_DRAIN;
               end else begin
                  stream_head_in  = item.line_addr;
                  stream_valid_in = 1'b1;
                  find_key_in     = stream_head_ff;
                  state_in        = stream_valid_ff ? ST_FIND_HEAD : ST_FIND_ADDR;
               end
            end
         end

         ST_FIND_HEAD: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (ent_match_v && key_rd_data == find_key_ff) begin
                  ent_sel_in = ent_cnt_ff;
                  state_in   = ST_META_HEAD;
               end else if (ent_last) begin
                  ent_cnt_in = '0;
                  state_in   = ST_FIND_ADDR;
               end else begin
                  ent_cnt_in = ent_cnt_ff + ENT_AW'(1);
               end
            end
         end

         ST_META_HEAD: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               meta_in  = meta_rd_data;
               pj_in    = '0;
               state_in = ST_PAIR_HEAD;
            end
         end

         ST_PAIR_HEAD: begin
            if (meta_ff.pair_valid[pj_ff] && !phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (meta_ff.pair_valid[pj_ff] &&
                   pair_rd_data.succ_key == item_ff.line_addr) begin
                  start_in    = pair_rd_data.hist_ptr;
                  ri_in       = RQ_AW'(1);
                  rq_head_in  = '0;
                  rq_count_in = '0;
                  state_in    = ST_REFILL;
               end else if (pj_last) begin
                  ent_cnt_in = '0;
                  state_in   = ST_FIND_ADDR;
               end else begin
                  pj_in = pj_ff + PAIR_JW'(1);
               end
            end
         end

         ST_FIND_ADDR: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (ent_match_v && key_rd_data == item_ff.line_addr) begin
                  ent_sel_in = ent_cnt_ff;
                  state_in   = ST_META_ADDR;
               end else if (ent_last) begin
                  state_in = ST_RECORD;
               end else begin
                  ent_cnt_in = ent_cnt_ff + ENT_AW'(1);
               end
            end
         end

         ST_META_ADDR: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in    = 1'b0;
               start_in    = meta_rd_data.recent_ptr;
               ri_in       = RQ_AW'(1);
               rq_head_in  = '0;
               rq_count_in = '0;
               state_in    = ST_REFILL;
            end
         end

         ST_REFILL: begin
            if (pos_ok && !phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (pos_ok) begin
                  rq_wr_en    = 1'b1;
                  rq_count_in = rq_count_ff + RQ_AW'(1);
               end
               if (ri_last) begin
                  burst_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  ri_in = ri_ff + RQ_AW'(1);
               end
            end
         end

         ST_DRAIN: begin
            if (rq_count_ff == '0) begin
               phase_in = 1'b0;
               state_in = ST_RECORD;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (out_free) begin
               phase_in     = 1'b0;
               out_valid_in = 1'b1;
               out_line_in  = LINE_W'(rq_rd_data >> LINE_LOG2);
               out_pc_in    = item_ff.load_pc;
               out_core_in  = item_ff.core_id;
               out_last_in  = (rq_count_ff == RQ_AW'(1)) || burst_last;
               rq_head_in   = (rq_head_ff == RQ_AW'(REPLAY_DEPTH - 1)) ? '0
                                                                       : rq_head_ff + RQ_AW'(1);
               rq_count_in  = rq_count_ff - RQ_AW'(1);
               burst_in     = burst_ff + BURST_CW'(1);
               if ((rq_count_ff == RQ_AW'(1)) || burst_last) begin
                  state_in = ST_RECORD;
               end
            end
         end

         ST_RECORD: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in   = 1'b0;
               old_in     = hist_rd_data;
               hist_wr_en = 1'b1;
               slot_in    = (slot_ff == HIST_AW'(HIST_DEPTH - 1)) ? '0 : slot_ff + HIST_AW'(1);
               total_in   = total_ff + PTR_W'(1);
               ent_cnt_in = '0;
               if (fill_ff == HIST_CW'(HIST_DEPTH)) begin
                  state_in = ST_EV_SCAN;
               end else begin
                  fill_in  = fill_ff + HIST_CW'(1);
                  state_in = ST_PREV;
               end
            end
         end

         ST_EV_SCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (ent_match_v && key_rd_data != old_ff) begin
                  meta_in  = meta_rd_data;
                  pj_in    = '0;
                  state_in = ST_EV_PAIR;
               end else begin
                  if (ent_match_v) begin
                     valid_in[ent_cnt_ff] = 1'b0;
                  end
                  if (ent_last) begin
                     state_in = ST_PREV;
                  end else begin
                     ent_cnt_in = ent_cnt_ff + ENT_AW'(1);
                  end
               end
            end
         end

         ST_EV_PAIR: begin
            if (meta_ff.pair_valid[pj_ff] && !phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (meta_ff.pair_valid[pj_ff] && pair_rd_data.succ_key == old_ff) begin
                  meta_in.pair_valid[pj_ff] = 1'b0;
                  state_in = ST_EV_FIN;
               end else if (pj_last) begin
                  state_in = ST_EV_FIN;
               end else begin
                  pj_in = pj_ff + PAIR_JW'(1);
               end
            end
         end

         ST_EV_FIN: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = ent_cnt_ff;
            if (meta_ff.pair_valid == '0) begin
               valid_in[ent_cnt_ff] = 1'b0;
            end
            if (ent_last) begin
               state_in = ST_PREV;
            end else begin
               ent_cnt_in = ent_cnt_ff + ENT_AW'(1);
               state_in   = ST_EV_SCAN;
            end
         end

         ST_PREV: begin
            if (!prev_valid_ff) begin
               prev_in       = item_ff.line_addr;
               prev_valid_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ent_cnt_in     = '0;
               free_found_in  = 1'b0;
               small_found_in = 1'b0;
               state_in       = ST_FIND_PREV;
            end
         end

         ST_FIND_PREV: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (ent_match_v && key_rd_data == prev_ff) begin
                  ent_sel_in = ent_cnt_ff;
                  state_in   = ST_UPD_META;
               end else begin
                  if (!ent_match_v && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_ent_in   = ent_cnt_ff;
                  end
                  if (ent_match_v && (!small_found_ff || key_rd_data < small_key_ff)) begin
                     small_found_in = 1'b1;
                     small_ent_in   = ent_cnt_ff;
                     small_key_in   = key_rd_data;
                  end
                  if (ent_last) begin
                     // allocate: first free entry, else the smallest key
                     alloc_ent           = free_found_in ? free_ent_in : small_ent_in;
                     key_wr_en           = 1'b1;
                     key_wr_addr         = alloc_ent;
                     valid_in[alloc_ent] = 1'b1;
                     ent_sel_in          = alloc_ent;
                     meta_in             = '0;
                     pj_in               = '0;
                     free_found_in       = 1'b0;
                     small_found_in      = 1'b0;
                     hit_found_in        = 1'b0;
                     state_in            = ST_UPD_PAIR;
                  end else begin
                     ent_cnt_in = ent_cnt_ff + ENT_AW'(1);
                  end
               end
            end
         end

         ST_UPD_META: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in       = 1'b0;
               meta_in        = meta_rd_data;
               pj_in          = '0;
               free_found_in  = 1'b0;
               small_found_in = 1'b0;
               hit_found_in   = 1'b0;
               state_in       = ST_UPD_PAIR;
            end
         end

         ST_UPD_PAIR: begin
            if (meta_ff.pair_valid[pj_ff] && !phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (meta_ff.pair_valid[pj_ff] &&
                   pair_rd_data.succ_key == item_ff.line_addr) begin
                  hit_found_in = 1'b1;
                  hit_j_in     = pj_ff;
                  hit_pair_in  = pair_rd_data;
                  state_in     = ST_UPD_WR;
               end else begin
                  if (!meta_ff.pair_valid[pj_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_j_in     = pj_ff;
                  end
                  if (meta_ff.pair_valid[pj_ff] &&
                      (!small_found_ff || pair_rd_data.succ_key < small_key_ff)) begin
                     small_found_in = 1'b1;
                     small_j_in     = pj_ff;
                     small_key_in   = pair_rd_data.succ_key;
                  end
                  if (pj_last) begin
                     state_in = ST_UPD_WR;
                  end else begin
                     pj_in = pj_ff + PAIR_JW'(1);
                  end
               end
            end
         end

         ST_UPD_WR: begin
            pair_wr_en = 1'b1;
            pair_wr_data.succ_key = item_ff.line_addr;
            if (hit_found_ff) begin
               upd_j                 = hit_j_ff;
               pair_wr_data.hist_ptr = (hit_pair_ff.timer == '0) ? upd_ptr
                                                                 : hit_pair_ff.hist_ptr;
               pair_wr_data.timer    = hit_pair_ff.timer + TIMER_W'(1);
            end else begin
               // new pair: free slot first, else replace the smallest successor
               upd_j                 = free_found_ff ? free_j_ff : small_j_ff;
               pair_wr_data.hist_ptr = upd_ptr;
               pair_wr_data.timer    = TIMER_W'(2);
            end
            pair_wr_addr = {ent_sel_ff, upd_j};
            meta_wr_en   = 1'b1;
            meta_wr_addr = ent_sel_ff;
            meta_wr_data.pair_valid        = meta_ff.pair_valid;
            meta_wr_data.pair_valid[upd_j] = 1'b1;
            meta_wr_data.recent_ptr = (meta_ff.upd_count == '0) ? upd_ptr : meta_ff.recent_ptr;
            meta_wr_data.upd_count  = meta_ff.upd_count + UCNT_W'(1);
            prev_in  = item_ff.line_addr;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= 1'b0;
         stream_valid_ff <= 1'b0;
         prev_valid_ff   <= 1'b0;
         total_ff        <= '0;
         fill_ff         <= '0;
         slot_ff         <= '0;
         valid_ff        <= '0;
         rq_head_ff      <= '0;
         rq_count_ff     <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         stream_valid_ff <= stream_valid_in;
         prev_valid_ff   <= prev_valid_in;
         total_ff        <= total_in;
         fill_ff         <= fill_in;
         slot_ff         <= slot_in;
         valid_ff        <= valid_in;
         rq_head_ff      <= rq_head_in;
         rq_count_ff     <= rq_count_in;
         out_valid_ff    <= out_valid_in;
      end
      item_ff        <= item_in;
      stream_head_ff <= stream_head_in;
      prev_ff        <= prev_in;
      old_ff         <= old_in;
      find_key_ff    <= find_key_in;
      ent_cnt_ff     <= ent_cnt_in;
      ent_sel_ff     <= ent_sel_in;
      pj_ff          <= pj_in;
      ri_ff          <= ri_in;
      start_ff       <= start_in;
      burst_ff       <= burst_in;
      meta_ff        <= meta_in;
      free_found_ff  <= free_found_in;
      free_ent_ff    <= free_ent_in;
      free_j_ff      <= free_j_in;
      small_found_ff <= small_found_in;
      small_ent_ff   <= small_ent_in;
      small_j_ff     <= small_j_in;
      small_key_ff   <= small_key_in;
      hit_found_ff   <= hit_found_in;
      hit_j_ff       <= hit_j_in;
      hit_pair_ff    <= hit_pair_in;
      out_line_ff    <= out_line_in;
      out_pc_ff      <= out_pc_in;
      out_core_ff    <= out_core_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.prefetch_line = out_line_ff;
   assign rsp_chan.req_pc        = out_pc_ff;
   assign rsp_chan.req_core      = out_core_ff;
   assign rsp_chan.last          = out_last_ff;
endmodule

`default_nettype wire

@@ hdl/temporal_miss_stream_prefetcher.sv @@
// Top level of the temporal miss-stream prefetcher: front end, event queue, back end.
// Depends on tmsp_pkg, tmsp_if, tmsp_front, tmsp_back (and tmsp_ram below it).
//
// Each transaction on req_chan is one event: a demand miss or a hit on a
// prefetched line. A hit drains up to BURST queued addresses as prefetch
// requests; a miss looks up the successor pair (stream head, this address),
// where the stream head is the previous miss and a hit clears it, falls back
// to the most recent history position of this address, refills the
// replay queue from the history that followed, and drains it. Every event is
// then recorded in the history ring and trains the index. Requests leave on
// rsp_chan, one transaction each, with last set on the final one of an event;
// an event that finds nothing gives no request. The front end buffers two
// events, so req_chan keeps accepting while the back end works. The back end
// handles one event at a time, and each memory access issues the address and
// then uses the registered read data. A miss adds up to two scans of the index
// (stream head, then this address), a pair scan and a refill of the replay
// queue; recording adds another index scan and pair scan.
// Once the history ring is full, each event also sweeps every index entry and
// its valid pairs to retire the overwritten address. The index and pair
// memories each have a single read port, so these scans read one entry or pair
// at a time. No clearing pass is needed after reset.
`default_nettype none

module temporal_miss_stream_prefetcher
   import tmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tmsp_req_if.sink    req_chan,
   tmsp_rsp_if.source  rsp_chan
);
   // classified events from the front end to the back end
   logic     item_valid;
   logic     item_ready;
   item_type item;

   // accept and queue events
   tmsp_front u_front (
      .clock,
      .reset,
      .req_chan,
      .item_valid,
      .item_ready,
      .item
   );

   // look up, refill, drain, record
   tmsp_back u_back (
      .clock,
      .reset,
      .item_valid,
      .item_ready,
      .item,
      .rsp_chan
   );
endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for temporal_miss_stream_prefetcher.
// Depends on tmsp_pkg and the tmsp_req_if / tmsp_rsp_if interfaces in hdl.
`timescale 1ns / 100ps

module testbench;
   import tmsp_pkg::*;

   localparam int N_RANDOM    = 280;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 12000;

   typedef struct {
      logic [LINE_W-1:0] line;
      logic [PC_W-1:0]   pc;
      logic [CORE_W-1:0] core;
      logic              last;
   } prefetch_type;

   logic clock;
   logic reset;

   tmsp_req_if req_if ();
   tmsp_rsp_if rsp_if ();

   temporal_miss_stream_prefetcher u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Shadow copy of the prefetcher state
   logic [ADDR_W-1:0]  hist_mem [HIST_DEPTH];
   int unsigned        hist_total, hist_fill, hist_slot;
   logic [ADDR_W-1:0]  ent_key [INDEX_ENTRIES];
   bit                 ent_valid [INDEX_ENTRIES];
   int unsigned        ent_recent [INDEX_ENTRIES];
   bit [UCNT_W-1:0]    ent_ucnt [INDEX_ENTRIES];
   logic [ADDR_W-1:0]  succ_addr [INDEX_ENTRIES*PAIRS_PER_ENTRY];
   int unsigned        succ_ptr [INDEX_ENTRIES*PAIRS_PER_ENTRY];
   bit [TIMER_W-1:0]   succ_timer [INDEX_ENTRIES*PAIRS_PER_ENTRY];
   bit                 succ_valid [INDEX_ENTRIES*PAIRS_PER_ENTRY];
   logic [ADDR_W-1:0]  replay_mem [REPLAY_DEPTH];
   int unsigned        replay_head, replay_count;
   logic [ADDR_W-1:0]  stream_addr, prev_miss;
   bit                 stream_vld, prev_vld;

   item_type     pending_events [$];
   prefetch_type expected_prefetches [$];
   int           error_count = 0;
   int           n_sent = 0;
   int           n_total = 0;
   int           cycle_count = 0;
   int           phase;

   function automatic int lookup_entry(logic [ADDR_W-1:0] key);
      for (int e = 0; e < INDEX_ENTRIES; e++)
         if (ent_valid[e] && ent_key[e] == key) return e;
      return -1;
   endfunction

   function automatic int lookup_succ(int e, logic [ADDR_W-1:0] nxt);
      int s;
      for (int j = 0; j < PAIRS_PER_ENTRY; j++) begin
         s = e * PAIRS_PER_ENTRY + j;
         if (succ_valid[s] && succ_addr[s] == nxt) return s;
      end
      return -1;
   endfunction

   // Reload the replay queue with history after position start, clipped to the window
   function automatic void reload_replay(int unsigned start);
      int unsigned pos, d, sl;
      replay_head  = 0;
      replay_count = 0;
      for (int unsigned i = 1; i < REPLAY_DEPTH; i++) begin
         pos = start + i;
         d   = hist_total - pos;
         if (d >= 1 && d <= hist_fill) begin
            sl = (hist_slot + HIST_DEPTH - (d % HIST_DEPTH)) % HIST_DEPTH;
            replay_mem[replay_count] = hist_mem[sl];
            replay_count++;
         end
      end
   endfunction

   function automatic void emit_burst(logic [PC_W-1:0] pc, logic [CORE_W-1:0] core);
      prefetch_type p;
      int n;
      n = 0;
      while (n < BURST && replay_count > 0) begin
         p.line = LINE_W'(replay_mem[replay_head % REPLAY_DEPTH] >> LINE_LOG2);
         p.pc   = pc;
         p.core = core;
         p.last = (n + 1 == BURST) || (replay_count == 1);
         expected_prefetches = {expected_prefetches, p};
         replay_head = (replay_head + 1) % REPLAY_DEPTH;
         replay_count--;
         n++;
      end
   endfunction

   function automatic void train_entry(int e, logic [ADDR_W-1:0] nxt, int unsigned ptr);
      int s, used, smallest, free_s, t;
      s = lookup_succ(e, nxt);
      if (s < 0) begin
         used = 0; smallest = -1; free_s = -1;
         for (int j = 0; j < PAIRS_PER_ENTRY; j++) begin
            t = e * PAIRS_PER_ENTRY + j;
            if (succ_valid[t]) begin
               used++;
               if (smallest < 0 || succ_addr[t] < succ_addr[smallest]) smallest = t;
            end else if (free_s < 0) begin
               free_s = t;
            end
         end
         // full set: evict the smallest successor
         if (used >= PAIRS_PER_ENTRY) free_s = smallest;
         s = free_s;
         succ_valid[s] = 1'b1;
         succ_addr[s]  = nxt;
         succ_ptr[s]   = ptr;
         succ_timer[s] = TIMER_W'(1);
      end
      if (succ_timer[s] == 0) succ_ptr[s] = ptr;
      if (ent_ucnt[e] == 0) ent_recent[e] = ptr;
      ent_ucnt[e]++;
      succ_timer[s]++;
   endfunction

   function automatic int claim_entry(logic [ADDR_W-1:0] key);
      int used, smallest, free_e;
      used = 0; smallest = -1; free_e = -1;
      for (int e = 0; e < INDEX_ENTRIES; e++) begin
         if (ent_valid[e]) begin
            used++;
            if (smallest < 0 || ent_key[e] < ent_key[smallest]) smallest = e;
         end else if (free_e < 0) begin
            free_e = e;
         end
      end
      if (used >= INDEX_ENTRIES) free_e = smallest;
      ent_valid[free_e]  = 1'b1;
      ent_key[free_e]    = key;
      ent_recent[free_e] = 0;
      ent_ucnt[free_e]   = '0;
      for (int j = 0; j < PAIRS_PER_ENTRY; j++) succ_valid[free_e * PAIRS_PER_ENTRY + j] = 1'b0;
      return free_e;
   endfunction

   function automatic void append_history(logic [ADDR_W-1:0] addr);
      bit evicting, any;
      logic [ADDR_W-1:0] old;
      int e, j;
      evicting = (hist_fill >= HIST_DEPTH);
      old = hist_mem[hist_slot];
      hist_mem[hist_slot] = addr;
      hist_slot = (hist_slot + 1) % HIST_DEPTH;
      hist_total++;
      if (!evicting) hist_fill++;
      if (evicting) begin
         // retire the overwritten address everywhere
         e = lookup_entry(old);
         if (e >= 0) ent_valid[e] = 1'b0;
         for (int k = 0; k < INDEX_ENTRIES; k++) begin
            if (ent_valid[k]) begin
               any = 1'b0;
               j = lookup_succ(k, old);
               if (j >= 0) succ_valid[j] = 1'b0;
               for (int m = 0; m < PAIRS_PER_ENTRY; m++)
                  if (succ_valid[k * PAIRS_PER_ENTRY + m]) any = 1'b1;
               if (!any) ent_valid[k] = 1'b0;
            end
         end
      end
      if (!prev_vld) begin
         prev_miss = addr;
         prev_vld  = 1'b1;
      end else begin
         e = lookup_entry(prev_miss);
         if (e < 0) e = claim_entry(prev_miss);
         train_entry(e, addr, hist_total - 1);
         prev_miss = addr;
      end
   endfunction

   // Work out the prefetches caused by one accepted event
   function automatic void predict_prefetches(item_type it);
      int e, s;
      bit had;
      logic [ADDR_W-1:0] old_head;
      if (it.kind == KIND_HIT) begin
         stream_vld = 1'b0;
         emit_burst(it.load_pc, it.core_id);
      end else begin
         had = stream_vld;
         old_head = stream_addr;
         stream_addr = it.line_addr;
         stream_vld  = 1'b1;
         e = had ? lookup_entry(old_head) : -1;
         s = (e >= 0) ? lookup_succ(e, it.line_addr) : -1;
         if (s >= 0) begin
            reload_replay(succ_ptr[s]);
            emit_burst(it.load_pc, it.core_id);
         end else begin
            e = lookup_entry(it.line_addr);
            if (e >= 0) begin
               reload_replay(ent_recent[e]);
               emit_burst(it.load_pc, it.core_id);
            end
         end
      end
      append_history(it.line_addr);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Drive all inputs known from time zero, then release reset
   initial begin
      reset = 1;
      req_if.valid = 0;
      req_if.line_addr = '0;
      req_if.is_hit = 0;
      req_if.load_pc = '0;
      req_if.core_id = '0;
      rsp_if.ready = 0;
      hist_total = 0; hist_fill = 0; hist_slot = 0;
      replay_head = 0; replay_count = 0;
      stream_addr = '0; stream_vld = 1'b0; prev_miss = '0; prev_vld = 1'b0;
      for (int e = 0; e < INDEX_ENTRIES; e++) begin
         ent_valid[e] = 1'b0; ent_recent[e] = 0; ent_ucnt[e] = '0;
      end
      for (int s = 0; s < INDEX_ENTRIES*PAIRS_PER_ENTRY; s++) begin
         succ_valid[s] = 1'b0; succ_timer[s] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 0;
   end

   // Stimulus: a directed opening, then replays of a training pattern with noise
   initial begin
      item_type it;
      logic [ADDR_W-1:0] pattern [24];
      logic [ADDR_W-1:0] dir_addr [6];
      int pos, len, r;

      for (int i = 0; i < 24; i++) pattern[i] = ADDR_W'({$urandom, $urandom});
      dir_addr[0] = '0;
      dir_addr[1] = '1;
      dir_addr[2] = 48'h0000_0000_0040;
      dir_addr[3] = 48'h8000_0000_0000;
      dir_addr[4] = 48'h5555_5555_5540;
      dir_addr[5] = 48'hAAAA_AAAA_AAAA;

      // hit with an empty queue, then a miss with no stream head and no entry
      it = '{KIND_HIT, dir_addr[5], '0, '0};
      pending_events = {pending_events, it};
      for (int rep = 0; rep < 3; rep++)
         for (int i = 0; i < 6; i++) begin
            it.kind = KIND_MISS;
            it.line_addr = dir_addr[i];
            it.load_pc = (i % 2) ? '1 : '0;
            it.core_id = (i % 2) ? 3'd7 : 3'd0;
            pending_events = {pending_events, it};
            // break the stream once so the most-recent fallback is used
            if (rep == 1 && i == 2) begin
               it.kind = KIND_HIT;
               pending_events = {pending_events, it};
            end
         end
      it = '{KIND_HIT, '1, '1, 3'd7};
      pending_events = {pending_events, it};
      pending_events = {pending_events, it};

      while (pending_events.size() < N_RANDOM) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            // replay a stretch of the pattern with random side fields
            pos = $urandom_range(0, 23);
            len = $urandom_range(2, 12);
            for (int k = 0; k < len; k++) begin
               it.kind = ($urandom_range(0, 99) < 15) ? KIND_HIT : KIND_MISS;
               it.line_addr = pattern[(pos + k) % 24];
               it.load_pc = PC_W'({$urandom, $urandom});
               it.core_id = CORE_W'($urandom_range(0, 7));
               pending_events = {pending_events, it};
            end
         end else begin
            it.kind = ($urandom_range(0, 99) < 30) ? KIND_HIT : KIND_MISS;
            it.line_addr = ADDR_W'({$urandom, $urandom});
            it.load_pc = PC_W'({$urandom, $urandom});
            it.core_id = CORE_W'($urandom_range(0, 7));
            pending_events = {pending_events, it};
         end
      end
      n_total = pending_events.size();

      // hold until every event is accepted, then drain expectations
      @(posedge clock);
      while (pending_events.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_prefetches.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_prefetches.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Driver: advance to the next event at the falling edge after an accept
   logic req_fire;
   always @(negedge clock) begin
      phase = (n_total == 0) ? 0 : (n_sent * 3) / n_total;
      if (!reset && (!req_if.valid || req_fire)) begin
         if (pending_events.size() != 0 && !(phase == 0 && $urandom_range(0, 99) < 15)
             && !(phase == 1 && $urandom_range(0, 99) < 83)) begin
            req_if.valid     <= 1;
            req_if.line_addr <= pending_events[0].line_addr;
            req_if.is_hit    <= (pending_events[0].kind == KIND_HIT);
            req_if.load_pc   <= pending_events[0].load_pc;
            req_if.core_id   <= pending_events[0].core_id;
            void'(pending_events.pop_front());
            n_sent++;
         end else begin
            req_if.valid <= 0;
         end
      end
      // receiver stalls: heavy first, light second, none last
      if (phase == 0)
         rsp_if.ready <= !reset && ($urandom_range(0, 99) >= 83);
      else if (phase == 1)
         rsp_if.ready <= !reset && ($urandom_range(0, 99) >= 15);
      else
         rsp_if.ready <= !reset;
   end

   // Monitor: predict on each accepted event, check each accepted request
   always @(posedge clock) begin
      item_type ev;
      prefetch_type exp_p;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      req_fire = !reset && req_if.valid && req_if.ready;
      if (req_fire) begin
         ev.kind      = req_if.is_hit ? KIND_HIT : KIND_MISS;
         ev.line_addr = req_if.line_addr;
         ev.load_pc   = req_if.load_pc;
         ev.core_id   = req_if.core_id;
         predict_prefetches(ev);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_prefetches.size() == 0) begin
            $display("%0t: unexpected request line=%h pc=%h core=%0d last=%b", $time,
                     rsp_if.prefetch_line, rsp_if.req_pc, rsp_if.req_core, rsp_if.last);
            error_count++;
         end else begin
            exp_p = expected_prefetches.pop_front();
            if (rsp_if.prefetch_line !== exp_p.line) begin
               $display("%0t: prefetch_line expected %h actual %h", $time, exp_p.line,
                        rsp_if.prefetch_line);
               error_count++;
            end
            if (rsp_if.req_pc !== exp_p.pc) begin
               $display("%0t: req_pc expected %h actual %h", $time, exp_p.pc, rsp_if.req_pc);
               error_count++;
            end
            if (rsp_if.req_core !== exp_p.core) begin
               $display("%0t: req_core expected %0d actual %0d", $time, exp_p.core,
                        rsp_if.req_core);
               error_count++;
            end
            if (rsp_if.last !== exp_p.last) begin
               $display("%0t: last expected %b actual %b", $time, exp_p.last, rsp_if.last);
               error_count++;
            end
         end
      end
   end

endmodule
